>>> rtl/erpm_pkg.sv
`timescale 1ns / 1ps

package erpm_pkg;

    localparam int NODE_ID_W  = 8;
    localparam int SEQ_W      = 16;
    localparam int ONSET_W    = 37;
    localparam int ARRIVAL_W  = 32;
    localparam int WINDOW_W   = 24;
    localparam int AGE_W      = 16;
    localparam int DELTA_W    = 25;
    localparam int DIST_W     = 34;
    localparam int OUT_NODE_W = 6;
    localparam int DIFF_W     = 38;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = WINDOW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT   = 2'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd600000;
    localparam logic [AGE_W-1:0]    AGE_RESET    = 16'd3000;

    localparam logic signed [DIFF_W-1:0] DAY_US      = 38'sd86400000000;
    localparam logic signed [DIFF_W-1:0] HALF_DAY_US = 38'sd43200000000;
    localparam logic signed [DIST_W-1:0] SOUND_SPEED = 34'sd343;

    typedef struct packed {
        logic load_in;
        logic seq_rd;
        logic seq_wr;
        logic walk_start;
        logic walk_issue;
        logic ring_wr;
        logic emit_rd;
        logic emit_ld;
    } erpm_cmd_t;

    typedef struct packed {
        logic node_ok;
        logic dup;
        logic issue_last;
        logic pipe_busy;
        logic has_match;
        logic emit_last;
        logic out_free;
    } erpm_sts_t;

endpackage

>>> rtl/erpm_ctrl.sv
`timescale 1ns / 1ps

module erpm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  erpm_pkg::erpm_sts_t  sts,
    output erpm_pkg::erpm_cmd_t  cmd
);
    import erpm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SEQ_RD  = 7'b0000010,
        S_SEQ_CHK = 7'b0000100,
        S_WALK    = 7'b0001000,
        S_DRAIN   = 7'b0010000,
        S_EMIT_RD = 7'b0100000,
        S_EMIT_LD = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_SEQ_RD;
                end
            end
            S_SEQ_RD:
            begin
                if (sts.node_ok)
                begin
                    cmd.seq_rd = 1'b1;
                    state_next = S_SEQ_CHK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEQ_CHK:
            begin
                if (sts.dup)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.seq_wr     = 1'b1;
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_issue = 1'b1;
                if (sts.issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // slot reads are all done; wait for the compare pipe to empty
                if (!sts.pipe_busy)
                begin
                    cmd.ring_wr = 1'b1;
                    state_next  = sts.has_match ? S_EMIT_RD : S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_ld = 1'b1;
                    state_next  = sts.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/erpm_dpath.sv
`timescale 1ns / 1ps

module erpm_dpath #(
    parameter int RING_DEPTH = 16,
    parameter int NODE_COUNT = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  erpm_pkg::erpm_cmd_t                    cmd,
    output erpm_pkg::erpm_sts_t                    sts,
    input  logic [erpm_pkg::WINDOW_W-1:0]          pair_window_us,
    input  logic [erpm_pkg::AGE_W-1:0]             age_limit_ms,
    input  logic [erpm_pkg::NODE_ID_W-1:0]         node_id,
    input  logic [erpm_pkg::SEQ_W-1:0]             seq_num,
    input  logic [erpm_pkg::ONSET_W-1:0]           onset_time,
    input  logic [erpm_pkg::ARRIVAL_W-1:0]         arrival_ms,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic [erpm_pkg::OUT_NODE_W-1:0]        this_node,
    output logic [erpm_pkg::OUT_NODE_W-1:0]        other_node,
    output logic signed [erpm_pkg::DELTA_W-1:0]    delta_us,
    output logic signed [erpm_pkg::DIST_W-1:0]     delta_dist_um,
    output logic                                   last
);
    import erpm_pkg::*;

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int RING_W  = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int ENTRY_W = NODE_W + ONSET_W + ARRIVAL_W;
    localparam int RES_W   = NODE_W + DELTA_W;
    localparam logic [CNT_W-1:0]       DEPTH_CNT  = CNT_W'(RING_DEPTH);
    localparam logic [RING_W-1:0]      LAST_SLOT  = RING_W'(RING_DEPTH - 1);
    localparam logic [NODE_ID_W:0]     NODE_LIMIT = (NODE_ID_W + 1)'(NODE_COUNT);

    // current report
    logic [NODE_ID_W-1:0] node_reg;
    logic [SEQ_W-1:0]     seq_reg;
    logic [ONSET_W-1:0]   onset_reg;
    logic [ARRIVAL_W-1:0] arrival_reg;
    logic [NODE_W-1:0]    node_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            node_reg    <= node_id;
            seq_reg     <= seq_num;
            onset_reg   <= onset_time;
            arrival_reg <= arrival_ms;
        end
    end

    assign node_idx    = node_reg[NODE_W-1:0];
    assign sts.node_ok = ({1'b0, node_reg} < NODE_LIMIT);

    // repeat filter: seen flags in flops, last sequence in a memory
    logic [NODE_COUNT-1:0] seen_reg;
    logic [SEQ_W-1:0]      seq_mem [NODE_COUNT];
    logic [SEQ_W-1:0]      seq_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.seq_wr)
        begin
            seq_mem[node_idx] <= seq_reg;
        end
        if (cmd.seq_rd)
        begin
            seq_rdata_reg <= seq_mem[node_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (cmd.seq_wr)
        begin
            seen_reg[node_idx] <= 1'b1;
        end
    end

    assign sts.dup = seen_reg[node_idx] && (seq_rdata_reg == seq_reg);

    // report ring
    logic [ENTRY_W-1:0]    ring_mem [RING_DEPTH];
    logic [ENTRY_W-1:0]    ring_rdata_reg;
    logic [RING_DEPTH-1:0] ring_valid_reg;
    logic [RING_W-1:0]     wr_ptr_reg;
    logic [CNT_W-1:0]      issue_cnt_reg;
    logic [RING_W-1:0]     issue_addr;

    assign issue_addr     = issue_cnt_reg[RING_W-1:0];
    assign sts.issue_last = (issue_cnt_reg == DEPTH_CNT - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.ring_wr)
        begin
            ring_mem[wr_ptr_reg] <= {node_idx, onset_reg, arrival_reg};
        end
        if (cmd.walk_issue)
        begin
            ring_rdata_reg <= ring_mem[issue_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_valid_reg <= '0;
            wr_ptr_reg     <= '0;
        end
        else if (cmd.ring_wr)
        begin
            ring_valid_reg[wr_ptr_reg] <= 1'b1;
            wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + RING_W'(1);
        end
    end

    // compare pipe: read, age/node/diff, day wrap, window
    logic                     p1_v_reg;
    logic                     p2_v_reg;
    logic                     p3_v_reg;
    logic [NODE_W-1:0]        p2_node_reg;
    logic [NODE_W-1:0]        p3_node_reg;
    logic signed [DIFF_W-1:0] p2_diff_reg;
    logic signed [DIFF_W-1:0] p3_d_reg;

    logic [NODE_W-1:0]        r_node;
    logic [ONSET_W-1:0]       r_onset;
    logic [ARRIVAL_W-1:0]     r_arrival;
    logic [ARRIVAL_W-1:0]     age;
    logic                     age_ok;
    logic                     node_ne;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] wrapped;
    logic signed [DIFF_W-1:0] win_s;
    logic                     match;

    assign {r_node, r_onset, r_arrival} = ring_rdata_reg;
    assign age     = arrival_reg - r_arrival;
    assign age_ok  = (age <= ARRIVAL_W'(age_limit_ms));
    assign node_ne = (r_node != node_idx);
    assign diff    = signed'(DIFF_W'(onset_reg)) - signed'(DIFF_W'(r_onset));

    always_comb
    begin
        wrapped = p2_diff_reg;
        if (p2_diff_reg > HALF_DAY_US)
        begin
            wrapped = p2_diff_reg - DAY_US;
        end
        else if (p2_diff_reg < -HALF_DAY_US)
        begin
            wrapped = p2_diff_reg + DAY_US;
        end
    end

    assign win_s = signed'(DIFF_W'(pair_window_us));
    assign match = p3_v_reg && (p3_d_reg <= win_s) && (p3_d_reg >= -win_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end
        else
        begin
            p1_v_reg <= cmd.walk_issue && ring_valid_reg[issue_addr];
            p2_v_reg <= p1_v_reg && age_ok && node_ne;
            p3_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_node_reg <= r_node;
        p2_diff_reg <= diff;
        p3_node_reg <= p2_node_reg;
        p3_d_reg    <= wrapped;
    end

    assign sts.pipe_busy = p1_v_reg || p2_v_reg || p3_v_reg;

    // matches are packed into a small result memory, then replayed
    logic [RES_W-1:0] res_mem [RING_DEPTH];
    logic [RES_W-1:0] res_rdata_reg;
    logic [CNT_W-1:0] match_cnt_reg;
    logic [CNT_W-1:0] emit_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (match)
        begin
            res_mem[match_cnt_reg[RING_W-1:0]] <= {p3_node_reg, p3_d_reg[DELTA_W-1:0]};
        end
        if (cmd.emit_rd)
        begin
            res_rdata_reg <= res_mem[emit_cnt_reg[RING_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            match_cnt_reg <= '0;
            emit_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.walk_start)
            begin
                issue_cnt_reg <= '0;
                match_cnt_reg <= '0;
                emit_cnt_reg  <= '0;
            end
            else
            begin
                if (cmd.walk_issue)
                begin
                    issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                end
                if (match)
                begin
                    match_cnt_reg <= match_cnt_reg + CNT_W'(1);
                end
                if (cmd.emit_ld)
                begin
                    emit_cnt_reg <= emit_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    assign sts.has_match = (match_cnt_reg != '0);
    assign sts.emit_last = (emit_cnt_reg == match_cnt_reg - CNT_W'(1));

    // output beat register
    logic                     out_valid_reg;
    logic [OUT_NODE_W-1:0]    this_node_reg;
    logic [OUT_NODE_W-1:0]    other_node_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic signed [DIST_W-1:0]  dist_reg;
    logic                     last_reg;
    logic signed [DELTA_W-1:0] res_delta;
    logic signed [DIST_W-1:0]  res_delta_ext;

    assign res_delta     = res_rdata_reg[DELTA_W-1:0];
    assign res_delta_ext = DIST_W'(res_delta);
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ld)
        begin
            this_node_reg  <= node_reg[OUT_NODE_W-1:0];
            other_node_reg <= OUT_NODE_W'(res_rdata_reg[RES_W-1:DELTA_W]);
            delta_reg      <= res_delta;
            dist_reg       <= res_delta_ext * SOUND_SPEED;
            last_reg       <= sts.emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign this_node     = this_node_reg;
    assign other_node    = other_node_reg;
    assign delta_us      = delta_reg;
    assign delta_dist_um = dist_reg;
    assign last          = last_reg;

endmodule

>>> rtl/event_report_pair_matcher.sv
`timescale 1ns / 1ps
// A dropped report returns to idle from the sequence read or check; a kept one walks
// every ring slot (one slot read per cycle), then waits for the compare pipe to drain.
// Each pair is then read from the result memory and loaded into the output register.
// One report at a time: no new report is taken until the last pair has been loaded.
// Reset (async, active low) clears seen flags, ring valid bits, write pointer, FSM
// and output valid; window and age limit return to 600000 us and 3000 ms.

module event_report_pair_matcher #(
    parameter int RING_DEPTH = 16,
    parameter int NODE_COUNT = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [erpm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [erpm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [erpm_pkg::NODE_ID_W-1:0]         node_id,
    input  logic [erpm_pkg::SEQ_W-1:0]             seq_num,
    input  logic [erpm_pkg::ONSET_W-1:0]           onset_time,
    input  logic [erpm_pkg::ARRIVAL_W-1:0]         arrival_ms,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [erpm_pkg::OUT_NODE_W-1:0]        this_node,
    output logic [erpm_pkg::OUT_NODE_W-1:0]        other_node,
    output logic signed [erpm_pkg::DELTA_W-1:0]    delta_us,
    output logic signed [erpm_pkg::DIST_W-1:0]     delta_dist_um,
    output logic                                   last
);
    import erpm_pkg::*;

    logic [WINDOW_W-1:0] window_reg;
    logic [AGE_W-1:0]    age_reg;
    erpm_cmd_t           cmd;
    erpm_sts_t           sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            age_reg    <= AGE_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_PAIR_WINDOW)
            begin
                window_reg <= cfg_data[WINDOW_W-1:0];
            end
            if (cfg_index == CFG_AGE_LIMIT)
            begin
                age_reg <= cfg_data[AGE_W-1:0];
            end
        end
    end

    erpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    erpm_dpath #(
        .RING_DEPTH (RING_DEPTH),
        .NODE_COUNT (NODE_COUNT)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .pair_window_us (window_reg),
        .age_limit_ms   (age_reg),
        .node_id        (node_id),
        .seq_num        (seq_num),
        .onset_time     (onset_time),
        .arrival_ms     (arrival_ms),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .this_node      (this_node),
        .other_node     (other_node),
        .delta_us       (delta_us),
        .delta_dist_um  (delta_dist_um),
        .last           (last)
    );

    // ring slot must not be overwritten while compares are still in flight
    a_no_ring_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.pipe_busy |-> !cmd.ring_wr)
        else $error("ring written during compare walk");

    // a waiting beat is never overwritten
    a_no_out_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_ld |-> sts.out_free)
        else $error("output register overrun");

    // more beats of this report follow, so no new report may be taken
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("new report taken before final pair beat");

endmodule
